// File: hdl/circular_angle_ema_filter_unit_macros.svh
// Assertion macros for the circular angle averaging filter.
// Used by the top level only; empty when SYNTHESIS is defined.
`ifndef CIRCULAR_ANGLE_EMA_FILTER_UNIT_MACROS_SVH
`define CIRCULAR_ANGLE_EMA_FILTER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define CAEF_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define CAEF_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define CAEF_ASSERT_SAME(label, clk, rst, ante, cons)
`define CAEF_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: hdl/caef_pkg.sv
// Shared types, constants and tables of the circular angle averaging filter.
// No dependencies.
package caef_pkg;

  localparam int ANGLE_W      = 14;
  localparam int TRIG_W       = 16;
  localparam int CORDIC_STEPS = 16;
  localparam int STEP_W       = 4;
  localparam int CW           = 34;  // CORDIC datapath, Q2.30 plus headroom
  localparam int ALPHA_W      = 16;
  localparam int CFG_AW       = 2;
  localparam int CFG_DW       = 16;

  localparam logic [CFG_AW-1:0]  REG_CLOCKWISE = 2'd0;
  localparam logic [CFG_AW-1:0]  REG_ALPHA     = 2'd1;
  localparam logic [ALPHA_W-1:0] ALPHA_RESET   = 16'd13107;
  localparam logic [ANGLE_W-1:0] ANGLE_MASK    = '1;
  localparam logic signed [CW-1:0] INV_GAIN    = 34'sd652032874;

  typedef struct packed {
    logic start;
    logic vec;    // 1: vectoring (atan2), 0: rotation (sin/cos)
  } cordic_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } cordic_sts_t;

  function automatic logic signed [CW-1:0] arc_at(input logic [STEP_W-1:0] i);
    logic signed [CW-1:0] r;
    unique case (i)
      4'd0:  r = 34'sh020000000;
      4'd1:  r = 34'sh012E4051E;
      4'd2:  r = 34'sh009FB385B;
      4'd3:  r = 34'sh0051111D4;
      4'd4:  r = 34'sh0028B0D43;
      4'd5:  r = 34'sh00145D7E1;
      4'd6:  r = 34'sh000A2F61E;
      4'd7:  r = 34'sh000517C55;
      4'd8:  r = 34'sh00028BE53;
      4'd9:  r = 34'sh000145F2F;
      4'd10: r = 34'sh0000A2F98;
      4'd11: r = 34'sh0000517CC;
      4'd12: r = 34'sh000028BE6;
      4'd13: r = 34'sh0000145F3;
      4'd14: r = 34'sh00000A2F9;
      default: r = 34'sh00000517D;
    endcase
    return r;
  endfunction

  // Q2.30 to Q1.15, round half up, saturate
  function automatic logic signed [TRIG_W-1:0] to_trig(input logic signed [CW-1:0] v);
    logic signed [CW-1:0] t;
    logic signed [TRIG_W-1:0] r;
    t = (v + (CW'(1) <<< (29 - (TRIG_W - 1)))) >>> (30 - (TRIG_W - 1));
    if (t > CW'((1 <<< (TRIG_W - 1)) - 1))
      r = {1'b0, {(TRIG_W-1){1'b1}}};
    else if (t < -(CW'(1) <<< (TRIG_W - 1)))
      r = {1'b1, {(TRIG_W-1){1'b0}}};
    else
      r = t[TRIG_W-1:0];
    return r;
  endfunction

endpackage

// File: hdl/circular_angle_ema_filter_unit.sv
// Top level of the circular angle averaging filter: control sequencer,
// filter state and output register. Depends on caef_pkg, caef_cordic,
// caef_sermul, caef_serdiv and circular_angle_ema_filter_unit_macros.svh.
//
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------
//  input    | in_valid / in_ready  | raw_angle
//  output   | out_valid / out_ready| angle, avg_angle, avg_valid
//  config   | wr_en                | wr_index, wr_data
//
// Each item goes through the 16-step CORDIC (sin/cos); in warm-up the sums
// are updated, the last warm-up sample adds the serial divide, and after
// warm-up the serial gain multiplier and a CORDIC atan2 follow.
// One item is in work at a time; the next is taken while a result waits.
// Reset clears the filter state, clockwise and alpha to their reset values.
// A stalled output holds the sequencer in its output state.
`include "circular_angle_ema_filter_unit_macros.svh"
module circular_angle_ema_filter_unit #(
  parameter int WARMUP_SAMPLES = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [caef_pkg::ANGLE_W-1:0]  raw_angle,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [caef_pkg::ANGLE_W-1:0]  angle,
  output logic [caef_pkg::ANGLE_W-1:0]  avg_angle,
  output logic                          avg_valid,
  input  logic                          wr_en,
  input  logic [caef_pkg::CFG_AW-1:0]   wr_index,
  input  logic [caef_pkg::CFG_DW-1:0]   wr_data
);
  import caef_pkg::*;

  localparam int CNT_W = $clog2(WARMUP_SAMPLES + 1);
  localparam int SUM_W = TRIG_W + $clog2(WARMUP_SAMPLES + 1);
  localparam int DW    = SUM_W + 1;
  localparam int PW    = DW + ALPHA_W;
  localparam int DV_W  = $clog2(WARMUP_SAMPLES + 1);
  localparam int SH    = 32 - ANGLE_W;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_ROT  = 4'd1;
  localparam logic [3:0] S_TRIG = 4'd2;
  localparam logic [3:0] S_DIV  = 4'd3;
  localparam logic [3:0] S_MUL  = 4'd4;
  localparam logic [3:0] S_EMA  = 4'd5;
  localparam logic [3:0] S_VEC  = 4'd6;
  localparam logic [3:0] S_OUT  = 4'd7;

  logic [3:0]              state;
  logic                    clockwise;
  logic [ALPHA_W-1:0]      alpha;
  logic [CNT_W-1:0]        sample_count;
  logic signed [SUM_W-1:0] sin_avg, cos_avg;
  logic [ANGLE_W-1:0]      average_angle, last_angle;
  logic [1:0]              quad;
  logic                    upd_valid;
  logic                    sin_neg, cos_neg;

  logic [ANGLE_W-1:0]      a_in;
  cordic_ctl_t             cctl;
  cordic_sts_t             csts;
  logic signed [CW-1:0]    cx_in, cy_in, cz_in, cx, cy, cz;
  logic signed [TRIG_W-1:0] s_new, c_new;
  logic signed [SUM_W-1:0] s_sum, c_sum;
  logic signed [DW-1:0]    ds, dc;
  logic                    mul_start, smul_done, cmul_done;
  logic signed [PW-1:0]    sprod, cprod;
  logic                    div_start, sdiv_done, cdiv_done;
  logic [SUM_W-1:0]        sq, cq;
  logic signed [CW-1:0]    vx, vy;
  logic [32:0]             phase_rnd;

  assign in_ready = (state == S_IDLE);
  assign a_in     = clockwise ? ANGLE_MASK - raw_angle : raw_angle;

  // sin/cos from the CORDIC result, per quadrant
  always_comb begin
    unique case (quad)
      2'd0: begin c_new = to_trig(cx);  s_new = to_trig(cy);  end
      2'd1: begin c_new = to_trig(-cy); s_new = to_trig(cx);  end
      2'd2: begin c_new = to_trig(-cx); s_new = to_trig(-cy); end
      default: begin c_new = to_trig(cy); s_new = to_trig(-cx); end
    endcase
  end

  assign s_sum = sin_avg + SUM_W'(s_new);
  assign c_sum = cos_avg + SUM_W'(c_new);
  assign ds    = DW'(s_new) - DW'(sin_avg);
  assign dc    = DW'(c_new) - DW'(cos_avg);
  assign vx    = CW'(cos_avg) <<< (30 - (TRIG_W - 1));
  assign vy    = CW'(sin_avg) <<< (30 - (TRIG_W - 1));
  assign phase_rnd = {1'b0, cz[31:0]} + (33'd1 << (SH - 1));

  always_comb begin
    cctl  = '{start: 1'b0, vec: 1'b0};
    cx_in = INV_GAIN;
    cy_in = '0;
    cz_in = CW'({a_in[ANGLE_W-3:0], {SH{1'b0}}});
    if (state == S_EMA) begin
      cctl.vec = 1'b1;
      cctl.start = (sin_avg != '0) || (cos_avg != '0);
      if (vx < 0) begin
        cx_in = -vx;
        cy_in = -vy;
        cz_in = CW'(1) <<< 31;
      end else begin
        cx_in = vx;
        cy_in = vy;
        cz_in = '0;
      end
    end else if (state == S_IDLE) begin
      cctl.start = in_valid;
    end
  end

  assign mul_start = (state == S_TRIG) && (sample_count == CNT_W'(WARMUP_SAMPLES));
  assign div_start = (state == S_TRIG) && (sample_count == CNT_W'(WARMUP_SAMPLES - 1));

  caef_cordic u_cordic (
    .clk(clk), .rst(rst), .ctl(cctl), .x_in(cx_in), .y_in(cy_in), .z_in(cz_in),
    .sts(csts), .x(cx), .y(cy), .z(cz)
  );

  caef_sermul #(.MW(DW)) u_smul (
    .clk(clk), .rst(rst), .start(mul_start), .mcand(ds), .mplier(alpha),
    .done(smul_done), .prod(sprod)
  );

  caef_sermul #(.MW(DW)) u_cmul (
    .clk(clk), .rst(rst), .start(mul_start), .mcand(dc), .mplier(alpha),
    .done(cmul_done), .prod(cprod)
  );

  caef_serdiv #(.N(SUM_W), .DV_W(DV_W)) u_sdiv (
    .clk(clk), .rst(rst), .start(div_start),
    .dividend(s_sum[SUM_W-1] ? SUM_W'(-s_sum) : SUM_W'(s_sum)),
    .divisor(DV_W'(WARMUP_SAMPLES)), .done(sdiv_done), .quotient(sq)
  );

  caef_serdiv #(.N(SUM_W), .DV_W(DV_W)) u_cdiv (
    .clk(clk), .rst(rst), .start(div_start),
    .dividend(c_sum[SUM_W-1] ? SUM_W'(-c_sum) : SUM_W'(c_sum)),
    .divisor(DV_W'(WARMUP_SAMPLES)), .done(cdiv_done), .quotient(cq)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      clockwise     <= 1'b0;
      alpha         <= ALPHA_RESET;
      sample_count  <= '0;
      sin_avg       <= '0;
      cos_avg       <= '0;
      average_angle <= '0;
      last_angle    <= '0;
      out_valid     <= 1'b0;
      upd_valid     <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            last_angle <= a_in;
            quad       <= a_in[ANGLE_W-1:ANGLE_W-2];
            state      <= S_ROT;
          end
        end
        S_ROT: begin
          if (csts.done) state <= S_TRIG;
        end
        S_TRIG: begin
          if (sample_count == CNT_W'(WARMUP_SAMPLES)) begin
            state <= S_MUL;
          end else if (sample_count == CNT_W'(WARMUP_SAMPLES - 1)) begin
            sin_neg <= s_sum[SUM_W-1];
            cos_neg <= c_sum[SUM_W-1];
            state   <= S_DIV;
          end else begin
            sin_avg      <= s_sum;
            cos_avg      <= c_sum;
            sample_count <= sample_count + 1'b1;
            upd_valid    <= 1'b0;
            state        <= S_OUT;
          end
        end
        S_DIV: begin
          if (sdiv_done) begin
            sin_avg      <= sin_neg ? -$signed(sq) : $signed(sq);
            cos_avg      <= cos_neg ? -$signed(cq) : $signed(cq);
            sample_count <= sample_count + 1'b1;
            upd_valid    <= 1'b0;
            state        <= S_OUT;
          end
        end
        S_MUL: begin
          if (smul_done) begin
            sin_avg <= sin_avg + SUM_W'((sprod + PW'(32768)) >>> 16);
            cos_avg <= cos_avg + SUM_W'((cprod + PW'(32768)) >>> 16);
            state   <= S_EMA;
          end
        end
        S_EMA: begin
          upd_valid <= 1'b1;
          if (cctl.start) begin
            state <= S_VEC;
          end else begin
            average_angle <= '0;  // zero vector
            state         <= S_OUT;
          end
        end
        S_VEC: begin
          if (csts.done) begin
            average_angle <= phase_rnd[31:SH];
            state         <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            angle     <= last_angle;
            avg_angle <= average_angle;
            avg_valid <= upd_valid;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (wr_en) begin
        if (wr_index == REG_CLOCKWISE) begin
          clockwise     <= wr_data[0];
          alpha         <= ALPHA_RESET;
          sample_count  <= '0;
          sin_avg       <= '0;
          cos_avg       <= '0;
          average_angle <= '0;
          last_angle    <= '0;
        end else if (wr_index == REG_ALPHA) begin
          alpha <= wr_data[ALPHA_W-1:0];
        end
      end
    end
  end

  `CAEF_ASSERT_SAME(a_count_range, clk, rst, 1'b1, sample_count <= CNT_W'(WARMUP_SAMPLES))
  `CAEF_ASSERT_SAME(a_valid_after_warmup, clk, rst, out_valid && avg_valid, sample_count == CNT_W'(WARMUP_SAMPLES))
  `CAEF_ASSERT_SAME(a_cordic_free, clk, rst, cctl.start, !csts.busy)
  `CAEF_ASSERT_NEXT(a_mul_after_warmup, clk, rst, mul_start, state == S_MUL)

endmodule

// File: hdl/caef_cordic.sv
// Iterative CORDIC, one micro-rotation per cycle, rotation or vectoring mode.
// Depends on caef_pkg.
module caef_cordic (
  input  logic                          clk,
  input  logic                          rst,
  input  caef_pkg::cordic_ctl_t         ctl,
  input  logic signed [caef_pkg::CW-1:0] x_in,
  input  logic signed [caef_pkg::CW-1:0] y_in,
  input  logic signed [caef_pkg::CW-1:0] z_in,
  output caef_pkg::cordic_sts_t         sts,
  output logic signed [caef_pkg::CW-1:0] x,
  output logic signed [caef_pkg::CW-1:0] y,
  output logic signed [caef_pkg::CW-1:0] z
);
  import caef_pkg::*;

  logic              busy;
  logic              done;
  logic              vec;
  logic [STEP_W-1:0] step;
  logic              sigma;
  logic signed [CW-1:0] xs, ys, arc;

  assign xs    = x >>> step;
  assign ys    = y >>> step;
  assign arc   = arc_at(step);
  assign sigma = vec ? !(y > 0) : !z[CW-1];
  assign sts   = '{busy: busy, done: done};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
      vec  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        vec  <= ctl.vec;
        step <= '0;
        x    <= x_in;
        y    <= y_in;
        z    <= z_in;
      end else if (busy) begin
        if (sigma) begin
          x <= x - ys;
          y <= y + xs;
          z <= z - arc;
        end else begin
          x <= x + ys;
          y <= y - xs;
          z <= z + arc;
        end
        step <= step + 1'b1;
        if (step == STEP_W'(CORDIC_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// File: hdl/caef_sermul.sv
// Bit-serial shift-add multiplier: signed multiplicand times unsigned gain,
// one gain bit per cycle. Depends on caef_pkg.
module caef_sermul #(
  parameter int MW = 22
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    start,
  input  logic signed [MW-1:0]                    mcand,
  input  logic [caef_pkg::ALPHA_W-1:0]            mplier,
  output logic                                    done,
  output logic signed [MW+caef_pkg::ALPHA_W-1:0]  prod
);
  import caef_pkg::*;

  localparam int PW  = MW + ALPHA_W;
  localparam int CNW = $clog2(ALPHA_W + 1);

  logic signed [PW-1:0] sh;
  logic [ALPHA_W-1:0]   m;
  logic [CNW-1:0]       cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        prod <= '0;
        sh   <= PW'(mcand);
        m    <= mplier;
        cnt  <= CNW'(ALPHA_W);
      end else if (cnt != '0) begin
        if (m[0]) prod <= prod + sh;
        sh  <= sh <<< 1;
        m   <= m >> 1;
        cnt <= cnt - 1'b1;
        if (cnt == CNW'(1)) done <= 1'b1;
      end
    end
  end

endmodule

// File: hdl/caef_serdiv.sv
// Restoring divider, one quotient bit per cycle, unsigned operands.
// Depends on caef_pkg.
module caef_serdiv #(
  parameter int N    = 21,
  parameter int DV_W = 9
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [N-1:0]    dividend,
  input  logic [DV_W-1:0] divisor,
  output logic            done,
  output logic [N-1:0]    quotient
);
  import caef_pkg::*;

  localparam int CNW = $clog2(N + 1);

  logic [DV_W-1:0] rem;
  logic [DV_W:0]   trial;
  logic [CNW-1:0]  cnt;

  assign trial = {rem, quotient[N-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem      <= '0;
        quotient <= dividend;
        cnt      <= CNW'(N);
      end else if (cnt != '0) begin
        if (trial >= {1'b0, divisor}) begin
          rem      <= DV_W'(trial - {1'b0, divisor});
          quotient <= {quotient[N-2:0], 1'b1};
        end else begin
          rem      <= trial[DV_W-1:0];
          quotient <= {quotient[N-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CNW'(1)) done <= 1'b1;
      end
    end
  end

endmodule

// File: tb/tb_circular_angle_ema_filter_unit.sv
// Testbench for the circular angle averaging filter: drives angle items and
// register writes, predicts each result with a CORDIC-exact model and checks it.
// Depends on caef_pkg and circular_angle_ema_filter_unit.
module tb_circular_angle_ema_filter_unit;
  import caef_pkg::*;

  localparam int WARMUP = 16;
  localparam longint CYCLE_LIMIT = 600000;

  typedef struct packed {
    logic [ANGLE_W-1:0] angle;
    logic [ANGLE_W-1:0] avg_angle;
    logic               avg_valid;
  } filt_result_t;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_ready;
  logic [ANGLE_W-1:0] raw_angle = '0;
  logic out_valid;
  logic out_ready = 0;
  logic [ANGLE_W-1:0] angle, avg_angle;
  logic avg_valid;
  logic wr_en = 0;
  logic [CFG_AW-1:0] wr_index = '0;
  logic [CFG_DW-1:0] wr_data = '0;

  // predictor state
  logic            cw_q;
  logic [15:0]     alpha_q;
  int              count_q;
  longint          sin_avg, cos_avg;
  logic [ANGLE_W-1:0] avg_ang_q;

  filt_result_t expected_q[$];
  int  errors = 0;
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  longint cycles = 0;

  circular_angle_ema_filter_unit DUT (.*);

  always #5 clk = ~clk;

  function automatic longint arc(int i);
    return longint'(arc_at(STEP_W'(i)));
  endfunction

  function automatic longint asr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint trig_round(longint v);
    longint r;
    r = asr(v + (64'sd1 << 14), 15);
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r;
  endfunction

  function automatic void angle_to_sincos(input logic [ANGLE_W-1:0] a, output longint s,
                                          output longint c);
    logic [31:0] ph;
    longint x, y, z, nx;
    ph = {a, 18'd0};
    z = longint'(ph[29:0]);
    x = 652032874;
    y = 0;
    for (int i = 0; i < 16; i++) begin
      if (z >= 0) begin
        nx = x - asr(y, i); y = y + asr(x, i); z -= arc(i);
      end else begin
        nx = x + asr(y, i); y = y - asr(x, i); z += arc(i);
      end
      x = nx;
    end
    case (ph[31:30])
      2'd0: begin c = trig_round(x);  s = trig_round(y);  end
      2'd1: begin c = trig_round(-y); s = trig_round(x);  end
      2'd2: begin c = trig_round(-x); s = trig_round(-y); end
      default: begin c = trig_round(y); s = trig_round(-x); end
    endcase
  endfunction

  function automatic logic [ANGLE_W-1:0] vector_to_angle(longint c, longint s);
    longint x, y, z, nx;
    logic [31:0] ph;
    logic [32:0] rnd;
    if (c == 0 && s == 0) return '0;
    x = c * 32768;
    y = s * 32768;
    z = 0;
    if (x < 0) begin
      x = -x; y = -y; z = 64'sd1 << 31;
    end
    for (int i = 0; i < 16; i++) begin
      if (y > 0) begin
        nx = x + asr(y, i); y = y - asr(x, i); z += arc(i);
      end else begin
        nx = x - asr(y, i); y = y + asr(x, i); z -= arc(i);
      end
      x = nx;
    end
    ph = z[31:0];
    rnd = {1'b0, ph} + 33'(1 << 17);
    return rnd[31:18];
  endfunction

  function automatic filt_result_t predict_filter(logic [ANGLE_W-1:0] raw);
    filt_result_t r;
    logic [ANGLE_W-1:0] a;
    longint s, c;
    a = cw_q ? ANGLE_MASK - raw : raw;
    angle_to_sincos(a, s, c);
    r.avg_valid = 1'b0;
    if (count_q < WARMUP) begin
      sin_avg += s;
      cos_avg += c;
      if (count_q == WARMUP - 1) begin
        sin_avg /= WARMUP;
        cos_avg /= WARMUP;
      end
      count_q++;
    end else begin
      sin_avg += asr(longint'(alpha_q) * (s - sin_avg) + 32768, 16);
      cos_avg += asr(longint'(alpha_q) * (c - cos_avg) + 32768, 16);
      sin_avg = longint'(int'(sin_avg));
      cos_avg = longint'(int'(cos_avg));
      avg_ang_q = vector_to_angle(cos_avg, sin_avg);
      r.avg_valid = 1'b1;
    end
    r.angle = a;
    r.avg_angle = avg_ang_q;
    return r;
  endfunction

  task automatic clear_model();
    count_q = 0; sin_avg = 0; cos_avg = 0; avg_ang_q = '0;
  endtask

  // writes only with nothing in flight
  task automatic write_reg(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] val);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    @(negedge clk);
    wr_en <= 1; wr_index <= idx; wr_data <= val;
    @(negedge clk);
    wr_en <= 0;
    if (idx == REG_CLOCKWISE) begin
      cw_q = val[0]; alpha_q = ALPHA_RESET; clear_model();
    end else if (idx == REG_ALPHA) begin
      alpha_q = val;
    end
  endtask

  // valid rises on a falling edge after the previous item dropped it, once the random idle wait (send_idle_pct) is over
  task automatic send_angle(logic [ANGLE_W-1:0] raw);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    @(negedge clk);
    in_valid <= 1;
    raw_angle <= raw;
    do @(posedge clk); while (!in_ready);
    expected_q.push_back(predict_filter(raw));
    @(negedge clk);
    in_valid <= 0;
  endtask

  always @(negedge clk) out_ready <= ($urandom_range(99) >= recv_stall_pct);

  always @(posedge clk) begin
    filt_result_t e;
    cycles++;
    if (!rst && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        $error("result with no item pending");
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (angle !== e.angle) begin
          $error("angle expected %0d actual %0d", e.angle, angle); errors++;
        end
        if (avg_angle !== e.avg_angle) begin
          $error("avg_angle expected %0d actual %0d", e.avg_angle, avg_angle); errors++;
        end
        if (avg_valid !== e.avg_valid) begin
          $error("avg_valid expected %0d actual %0d", e.avg_valid, avg_valid); errors++;
        end
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic test_directed();
    logic [ANGLE_W-1:0] pts[8] = '{0, 16383, 4096, 8192, 12288, 1, 8191, 2048};
    for (int i = 0; i < 24; i++) send_angle(pts[i % 8]);
    write_reg(REG_CLOCKWISE, 16'd1);
    for (int i = 0; i < 20; i++) send_angle(pts[i % 8]);
    // opposite angles cancel to a zero vector
    write_reg(REG_CLOCKWISE, 16'd0);
    for (int i = 0; i < 18; i++) send_angle((i % 2) ? 14'd8192 : 14'd0);
    write_reg(REG_ALPHA, 16'd0);
    for (int i = 0; i < 3; i++) send_angle(14'd5000);
    write_reg(REG_ALPHA, 16'hFFFF);
    for (int i = 0; i < 3; i++) send_angle(14'h3FFF);
    write_reg(2'd3, 16'h1234);  // unmapped index, no effect
    send_angle(14'd100);
  endtask

  // angles within +-300 of a random center (wrapping mod 16384), one in ten fully random, center redrawn at random
  task automatic test_random(int n, int cw, logic [15:0] alp);
    int center;
    write_reg(REG_CLOCKWISE, 16'(cw));
    write_reg(REG_ALPHA, alp);
    center = $urandom_range(16383);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0)
        send_angle(14'($urandom));
      else
        send_angle(14'(center + $urandom_range(600) - 300));
      if ($urandom_range(40) == 0) center = $urandom_range(16383);
    end
  endtask

  initial begin
    cw_q = 0; alpha_q = ALPHA_RESET; clear_model();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    test_directed();
    test_random(300, 0, 16'd13107);
    send_idle_pct = 67;
    test_random(300, 1, 16'd1);
    send_idle_pct = 0; recv_stall_pct = 67;
    test_random(300, 0, 16'd65535);
    send_idle_pct = 17; recv_stall_pct = 17;
    test_random(330, 1, 16'($urandom_range(65535)));
    while (expected_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end
endmodule

// File: filelist.f
+incdir+hdl
hdl/caef_pkg.sv
hdl/caef_cordic.sv
hdl/caef_sermul.sv
hdl/caef_serdiv.sv
hdl/circular_angle_ema_filter_unit.sv
tb/tb_circular_angle_ema_filter_unit.sv
